[design/lattice_translation_permutation_macros.svh]
// Assertion macros shared by the lattice translation permutation RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LATTICE_TRANSLATION_PERMUTATION_MACROS_SVH
`define LATTICE_TRANSLATION_PERMUTATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ltp_pkg.sv]
// Shared types and constants for the lattice translation permutation block.
// No dependencies; imported by every module of the block.
package ltp_pkg;

    localparam int TRANS_W = 12;   // translation_index
    localparam int ATOM_W  = 18;   // source_atom, permuted_atom
    localparam int RAD_W   = 5;    // radix registers
    localparam int NA_W    = 7;    // atoms_per_cell register
    localparam int PLANE_W = 10;   // radix_second * radix_third
    localparam int CELLS_W = 15;   // cells in the supercell
    localparam int TOTAL_W = 22;   // cells * atoms_per_cell
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_RADIX_FIRST  = 2'd0,
        REG_RADIX_SECOND = 2'd1,
        REG_RADIX_THIRD  = 2'd2,
        REG_ATOMS        = 2'd3
    } reg_idx_t;

    // Clamped configuration plus the derived sizes, ready for the datapath.
    typedef struct packed {
        logic [RAD_W-1:0]   r1;
        logic [RAD_W-1:0]   r2;
        logic [RAD_W-1:0]   r3;
        logic [NA_W-1:0]    na;
        logic [PLANE_W-1:0] plane;
        logic [CELLS_W-1:0] cells;
        logic [TOTAL_W-1:0] total;
        logic               busy;
    } cfg_t;

    // Zero reads as one, anything above top saturates to top.
    function automatic logic [NA_W-1:0] clamp_cfg(input logic [NA_W-1:0] v, input int top);
        logic [NA_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = NA_W'(1);
        end else if (int'(v) > top) begin
            res = NA_W'(top);
        end
        return res;
    endfunction

endpackage

[design/ltp_cfg.sv]
// Register file of the block: APB-style write/read of the four size registers,
// clamping, and the registered chain that forms plane, cell and atom counts. Uses ltp_pkg.
module ltp_cfg #(
    parameter int MAX_RADIX          = 16,
    parameter int MAX_ATOMS_PER_CELL = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ltp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ltp_pkg::DATA_W-1:0]  pwdata,
    output logic [ltp_pkg::DATA_W-1:0]  prdata,
    output ltp_pkg::cfg_t               cfg
);
    import ltp_pkg::*;

    // write -> clamp -> plane -> cells -> total
    localparam logic [2:0] SETTLE = 3'd4;

    logic [RAD_W-1:0]   radix_first_reg;
    logic [RAD_W-1:0]   radix_second_reg;
    logic [RAD_W-1:0]   radix_third_reg;
    logic [NA_W-1:0]    atoms_reg;
    logic [RAD_W-1:0]   r1_reg, r2_reg, r3_reg;
    logic [NA_W-1:0]    na_reg;
    logic [RAD_W-1:0]   r1_next, r2_next, r3_next;
    logic [NA_W-1:0]    na_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [CELLS_W-1:0] cells_reg, cells_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [2:0]         settle_reg, settle_next;
    logic               wr_en;
    reg_idx_t           idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_first_reg  <= RAD_W'(1);
            radix_second_reg <= RAD_W'(1);
            radix_third_reg  <= RAD_W'(1);
            atoms_reg        <= NA_W'(1);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RADIX_FIRST:  radix_first_reg  <= pwdata[RAD_W-1:0];
                REG_RADIX_SECOND: radix_second_reg <= pwdata[RAD_W-1:0];
                REG_RADIX_THIRD:  radix_third_reg  <= pwdata[RAD_W-1:0];
                REG_ATOMS:        atoms_reg        <= pwdata[NA_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RADIX_FIRST:  prdata = DATA_W'(radix_first_reg);
            REG_RADIX_SECOND: prdata = DATA_W'(radix_second_reg);
            REG_RADIX_THIRD:  prdata = DATA_W'(radix_third_reg);
            REG_ATOMS:        prdata = DATA_W'(atoms_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        r1_next     = RAD_W'(clamp_cfg(NA_W'(radix_first_reg), MAX_RADIX));
        r2_next     = RAD_W'(clamp_cfg(NA_W'(radix_second_reg), MAX_RADIX));
        r3_next     = RAD_W'(clamp_cfg(NA_W'(radix_third_reg), MAX_RADIX));
        na_next     = clamp_cfg(atoms_reg, MAX_ATOMS_PER_CELL);
        plane_next  = PLANE_W'(r2_reg) * PLANE_W'(r3_reg);
        cells_next  = CELLS_W'(r1_reg) * CELLS_W'(plane_reg);
        total_next  = TOTAL_W'(cells_reg) * TOTAL_W'(na_reg);
        settle_next = wr_en ? SETTLE : ((settle_reg != '0) ? settle_reg - 3'd1 : settle_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg     <= RAD_W'(1);
            r2_reg     <= RAD_W'(1);
            r3_reg     <= RAD_W'(1);
            na_reg     <= NA_W'(1);
            plane_reg  <= PLANE_W'(1);
            cells_reg  <= CELLS_W'(1);
            total_reg  <= TOTAL_W'(1);
            settle_reg <= '0;
        end
        else
        begin
            r1_reg     <= r1_next;
            r2_reg     <= r2_next;
            r3_reg     <= r3_next;
            na_reg     <= na_next;
            plane_reg  <= plane_next;
            cells_reg  <= cells_next;
            total_reg  <= total_next;
            settle_reg <= settle_next;
        end
    end

    assign cfg.r1    = r1_reg;
    assign cfg.r2    = r2_reg;
    assign cfg.r3    = r3_reg;
    assign cfg.na    = na_reg;
    assign cfg.plane = plane_reg;
    assign cfg.cells = cells_reg;
    assign cfg.total = total_reg;
    assign cfg.busy  = (settle_reg != '0);

endmodule

[design/ltp_divpipe.sv]
// Pipelined restoring divider: one quotient bit per stage, LANES numerators
// over one shared divisor, with a side payload. Uses ltp_pkg and the macros header.
`include "lattice_translation_permutation_macros.svh"

module ltp_divpipe #(
    parameter int LANES = 1,
    parameter int NUM_W = 18,
    parameter int DEN_W = 15,
    parameter int Q_W   = 6,
    parameter int PAY_W = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [LANES-1:0][NUM_W-1:0]  in_num,
    input  logic [PAY_W-1:0]             in_pay,
    input  logic [DEN_W-1:0]             den,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [LANES-1:0][Q_W-1:0]    out_quo,
    output logic [LANES-1:0][DEN_W-1:0]  out_rem,
    output logic [PAY_W-1:0]             out_pay
);
    import ltp_pkg::*;

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam logic [Q_W-1:0] TOP_BIT  = Q_W'(1) << (Q_W - 1);
    localparam logic [Q_W-1:0] LOW_MASK = ~TOP_BIT;

    logic [Q_W-1:0]                vld_reg;
    logic [LANES-1:0][W-1:0]       rem_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]     quo_reg [Q_W];
    logic [PAY_W-1:0]              pay_reg [Q_W];
    logic [Q_W:0]                  ld;

    assign ld[Q_W] = !out_stall;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int SH = Q_W - 1 - k;
        localparam logic [Q_W-1:0] QBIT = Q_W'(1) << SH;

        logic [LANES-1:0][W-1:0]   rem_src;
        logic [LANES-1:0][Q_W-1:0] quo_src;
        logic [PAY_W-1:0]          pay_src;
        logic                      vld_src;
        logic [LANES-1:0][W-1:0]   rem_next;
        logic [LANES-1:0][Q_W-1:0] quo_next;
        logic [W-1:0]              trial;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = W'(in_num[l]);
                    quo_src[l] = '0;
                end
            end
            assign pay_src = in_pay;
            assign vld_src = in_valid;
        end
        else
        begin : g_rest
            assign rem_src = rem_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign pay_src = pay_reg[k-1];
            assign vld_src = vld_reg[k-1];
        end

        // a stage may load when empty or when its item moves on
        assign ld[k] = !vld_reg[k] || ld[k+1];
        assign trial = W'(den) << SH;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_src[l] >= trial)
                begin
                    rem_next[l] = rem_src[l] - trial;
                    quo_next[l] = quo_src[l] | QBIT;
                end
                else
                begin
                    rem_next[l] = rem_src[l];
                    quo_next[l] = quo_src[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ld[k])
            begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k] && vld_src)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                pay_reg[k] <= pay_src;
            end
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[Q_W-1];
    assign out_pay   = pay_reg[Q_W-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[Q_W-1][l];
            out_rem[l] = rem_reg[Q_W-1][l][DEN_W-1:0];
        end
    end

    // input only backs up once every stage is occupied
    `LTP_ASSERT_SAME(a_div_full_on_stall, in_stall, &vld_reg, "divider stalled with a free stage")
    // items in flight change only by requests taken in and handed out
    `LTP_ASSERT_SAME(a_div_count, $past(rst_n),
        $countones(vld_reg) == $past($countones(vld_reg)) + $past(in_valid && !in_stall)
            - $past(out_valid && !out_stall),
        "divider lost or duplicated a request")
    // the first stage decides only the top quotient bit
    `LTP_ASSERT_SAME(a_div_first_bit, vld_reg[0], (quo_reg[0][0] & LOW_MASK) == '0,
        "first divider stage set a low quotient bit")

endmodule

[design/ltp_pack.sv]
// Back end: digit-wise modular add, scaling by the place values, and the final
// sum with the sublattice offset into the output register. Uses ltp_pkg.
module ltp_pack #(
    parameter int DIG_W = 4,
    parameter int SUB_W = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0][DIG_W-1:0]           c_dig,
    input  logic [2:0][DIG_W-1:0]           t_dig,
    input  logic [SUB_W-1:0]                sub,
    input  logic                            err,
    input  ltp_pkg::cfg_t                   cfg,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ltp_pkg::ATOM_W-1:0]      permuted_atom,
    output logic                            range_error
);
    import ltp_pkg::*;

    localparam int AW    = ((DIG_W > RAD_W) ? DIG_W : RAD_W) + 1;
    localparam int M1_W  = DIG_W + PLANE_W;
    localparam int M2_W  = DIG_W + RAD_W;
    localparam int M3_W  = SUB_W + CELLS_W;
    localparam int SUM_W = ((M1_W > M3_W) ? M1_W : M3_W) + 2;

    logic [2:0][RAD_W-1:0] radix;

    // stage 1: modular digit sums
    logic                   v1_reg;
    logic [2:0][DIG_W-1:0]  dig_reg, dig_next;
    logic [SUB_W-1:0]       sub1_reg;
    logic                   err1_reg;
    // stage 2: place-value products
    logic                   v2_reg;
    logic [M1_W-1:0]        m1_reg, m1_next;
    logic [M2_W-1:0]        m2_reg, m2_next;
    logic [M3_W-1:0]        m3_reg, m3_next;
    logic [DIG_W-1:0]       d3_reg;
    logic                   err2_reg;
    // stage 3: output register
    logic                   v3_reg;
    logic [ATOM_W-1:0]      res_reg, res_next;
    logic                   err3_reg;
    logic [SUM_W-1:0]       sum;
    logic                   ld1, ld2, ld3;

    assign radix[0] = cfg.r1;
    assign radix[1] = cfg.r2;
    assign radix[2] = cfg.r3;

    assign ld3      = !v3_reg || !out_stall;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_stall = !ld1;

    always_comb
    begin
        logic [AW-1:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = AW'(c_dig[i]) + AW'(t_dig[i]);
            if (s >= AW'(radix[i]))
            begin
                s = s - AW'(radix[i]);
            end
            dig_next[i] = DIG_W'(s);
        end
    end

    always_comb
    begin
        m1_next  = M1_W'(dig_reg[0]) * M1_W'(cfg.plane);
        m2_next  = M2_W'(dig_reg[1]) * M2_W'(cfg.r3);
        m3_next  = M3_W'(sub1_reg) * M3_W'(cfg.cells);
        sum      = SUM_W'(m1_reg) + SUM_W'(m2_reg) + SUM_W'(m3_reg) + SUM_W'(d3_reg);
        res_next = err2_reg ? '0 : sum[ATOM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            dig_reg  <= dig_next;
            sub1_reg <= sub;
            err1_reg <= err;
        end
        if (ld2 && v1_reg)
        begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            m3_reg   <= m3_next;
            d3_reg   <= dig_reg[2];
            err2_reg <= err1_reg;
        end
        if (ld3 && v2_reg)
        begin
            res_reg  <= res_next;
            err3_reg <= err2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign permuted_atom = res_reg;
    assign range_error   = err3_reg;

endmodule

[design/lattice_translation_permutation.sv]
// Lattice translation permutation entry: one request in and one result out per
// cycle unless result_stall or a settle window holds the flow. In order: an entry
// stage with the range check, a restoring divider that splits the atom index into
// sublattice and cell (one quotient bit per stage), two dividers that peel off the
// axis-one and axis-two digits of the cell and of the translation in parallel,
// then modular add, scaling and final sum. The pipeline collapses bubbles, so a
// request is taken whenever any stage ahead can move. After every register write
// the request side stalls while the plane, cell and atom counts are recomputed.
// Depends on ltp_pkg, ltp_cfg, ltp_divpipe, ltp_pack and the macros header.
`include "lattice_translation_permutation_macros.svh"

module lattice_translation_permutation #(
    parameter int MAX_RADIX          = 16,
    parameter int MAX_ATOMS_PER_CELL = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ltp_pkg::ADDR_W-1:0]   paddr,
    input  logic [ltp_pkg::DATA_W-1:0]   pwdata,
    output logic [ltp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [ltp_pkg::TRANS_W-1:0]  translation_index,
    input  logic [ltp_pkg::ATOM_W-1:0]   source_atom,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ltp_pkg::ATOM_W-1:0]   permuted_atom,
    output logic                         range_error
);
    import ltp_pkg::*;

    localparam int DIG_W  = $clog2(MAX_RADIX);
    localparam int SUB_W  = (MAX_ATOMS_PER_CELL > 1) ? $clog2(MAX_ATOMS_PER_CELL) : 1;
    localparam int PAY1_W = TRANS_W + 1;
    localparam int PAY2_W = SUB_W + 1;
    localparam int PAY3_W = SUB_W + 1 + 2 * DIG_W;

    cfg_t cfg_s;

    // entry stage
    logic                ent_vld_reg;
    logic [TRANS_W-1:0]  t_reg;
    logic [ATOM_W-1:0]   a_reg;
    logic                err_reg, err_next;
    logic                ent_ld;

    // atom / cells
    logic                           d1_in_stall, d1_vld, d1_stall;
    logic [0:0][ATOM_W-1:0]         d1_num;
    logic [0:0][SUB_W-1:0]          d1_quo;
    logic [0:0][CELLS_W-1:0]        d1_rem;
    logic [PAY1_W-1:0]              d1_pay;
    // cell and translation / plane
    logic                           d2_vld, d2_stall;
    logic [1:0][CELLS_W-1:0]        d2_num;
    logic [1:0][DIG_W-1:0]          d2_quo;
    logic [1:0][PLANE_W-1:0]        d2_rem;
    logic [PAY2_W-1:0]              d2_pay;
    // remainders / radix_third
    logic                           d3_vld, d3_stall;
    logic [1:0][DIG_W-1:0]          d3_quo;
    logic [1:0][RAD_W-1:0]          d3_rem;
    logic [PAY3_W-1:0]              d3_pay;

    logic [2:0][DIG_W-1:0]          c_dig, t_dig;
    logic [SUB_W-1:0]               sub3;
    logic                           err3;

    assign pready = 1'b1;

    ltp_cfg #(
        .MAX_RADIX          (MAX_RADIX),
        .MAX_ATOMS_PER_CELL (MAX_ATOMS_PER_CELL)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg_s)
    );

    assign ent_ld     = !ent_vld_reg || !d1_in_stall;
    assign item_stall = cfg_s.busy || !ent_ld;
    assign err_next   = (CELLS_W'(translation_index) >= cfg_s.cells)
                        || (TOTAL_W'(source_atom) >= cfg_s.total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
        end
        else if (ent_ld)
        begin
            ent_vld_reg <= item_valid && !cfg_s.busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            t_reg   <= translation_index;
            a_reg   <= source_atom;
            err_reg <= err_next;
        end
    end

    assign d1_num[0] = a_reg;

    ltp_divpipe #(
        .LANES (1),
        .NUM_W (ATOM_W),
        .DEN_W (CELLS_W),
        .Q_W   (SUB_W),
        .PAY_W (PAY1_W)
    ) u_div_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ent_vld_reg),
        .in_stall  (d1_in_stall),
        .in_num    (d1_num),
        .in_pay    ({t_reg, err_reg}),
        .den       (cfg_s.cells),
        .out_valid (d1_vld),
        .out_stall (d1_stall),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_pay   (d1_pay)
    );

    // lane 1 carries the cell index, lane 0 the translation
    assign d2_num[1] = d1_rem[0];
    assign d2_num[0] = CELLS_W'(d1_pay[PAY1_W-1:1]);

    ltp_divpipe #(
        .LANES (2),
        .NUM_W (CELLS_W),
        .DEN_W (PLANE_W),
        .Q_W   (DIG_W),
        .PAY_W (PAY2_W)
    ) u_div_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_vld),
        .in_stall  (d1_stall),
        .in_num    (d2_num),
        .in_pay    ({d1_quo[0], d1_pay[0]}),
        .den       (cfg_s.plane),
        .out_valid (d2_vld),
        .out_stall (d2_stall),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_pay   (d2_pay)
    );

    ltp_divpipe #(
        .LANES (2),
        .NUM_W (PLANE_W),
        .DEN_W (RAD_W),
        .Q_W   (DIG_W),
        .PAY_W (PAY3_W)
    ) u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_vld),
        .in_stall  (d2_stall),
        .in_num    (d2_rem),
        .in_pay    ({d2_pay, d2_quo[1], d2_quo[0]}),
        .den       (cfg_s.r3),
        .out_valid (d3_vld),
        .out_stall (d3_stall),
        .out_quo   (d3_quo),
        .out_rem   (d3_rem),
        .out_pay   (d3_pay)
    );

    assign sub3     = d3_pay[PAY3_W-1:2*DIG_W+1];
    assign err3     = d3_pay[2*DIG_W];
    assign c_dig[0] = d3_pay[2*DIG_W-1:DIG_W];
    assign t_dig[0] = d3_pay[DIG_W-1:0];
    assign c_dig[1] = d3_quo[1];
    assign t_dig[1] = d3_quo[0];
    assign c_dig[2] = DIG_W'(d3_rem[1]);
    assign t_dig[2] = DIG_W'(d3_rem[0]);

    ltp_pack #(
        .DIG_W (DIG_W),
        .SUB_W (SUB_W)
    ) u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (d3_vld),
        .in_stall      (d3_stall),
        .c_dig         (c_dig),
        .t_dig         (t_dig),
        .sub           (sub3),
        .err           (err3),
        .cfg           (cfg_s),
        .out_valid     (result_valid),
        .out_stall     (result_stall),
        .permuted_atom (permuted_atom),
        .range_error   (range_error)
    );

    // no request is taken while the derived sizes are settling
    `LTP_ASSERT_SAME(a_busy_holds_input, cfg_s.busy, item_stall,
        "request taken while configuration settles")
    // a register write always opens a settle window
    `LTP_ASSERT_NEXT(a_write_settles, psel && penable && pwrite, cfg_s.busy,
        "register write did not start a settle window")
    // flagged results carry a zero index
    `LTP_ASSERT_SAME(a_error_zero, result_valid && range_error, permuted_atom == '0,
        "range error with a nonzero index")

endmodule
